[hw/rtl/bba_pkg.sv]
// Shared constants, item kinds and control types for the block bitmap allocator.
package bba_pkg;

  localparam int NUM_BLOCKS_DEF = 256;

  localparam int WORD_BITS = 16;
  localparam int WBIT_W    = 4;

  localparam int KIND_W  = 3;
  localparam int IDX_W   = 8;
  localparam int HDR_W   = 8;
  localparam int BLKS_W  = 9;
  localparam int BYTES_W = 15;
  localparam int CFG_W   = 7;

  localparam logic [BLKS_W-1:0]  BLOCKS_MAX = 9'd511;
  localparam logic [BYTES_W-1:0] BYTES_MAX  = 15'd32767;

  localparam logic [KIND_W-1:0] KIND_INIT_CLEAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INIT_HEADER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INIT_FINISH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ALLOC       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASE     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MASTER_SET  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_MASTER_CLR  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SEEK_FMT    = 3'd7;

  localparam logic CFG_DATA_BYTES = 1'b0;
  localparam logic CFG_NAME_BYTES = 1'b1;

  localparam logic [CFG_W-1:0] DATA_BYTES_RST = 7'd29;
  localparam logic [CFG_W-1:0] NAME_BYTES_RST = 7'd16;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } map_ctl_t;

endpackage

[hw/rtl/bba_ifs.sv]
// Valid/ready channel interfaces for allocator requests and results.
interface bba_in_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  block_index;
  logic              skip_valid;
  logic [HDR_W-1:0]  header_byte;
  logic              format_select;

  modport source (output valid, kind, block_index, skip_valid, header_byte, format_select,
                  input ready);
  modport sink (input valid, kind, block_index, skip_valid, header_byte, format_select,
                output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [IDX_W-1:0]   found_index;
  logic [BLKS_W-1:0]  free_block_count;
  logic [BYTES_W-1:0] free_byte_count;

  modport source (output valid, status, found_index, free_block_count, free_byte_count,
                  input ready);
  modport sink (input valid, status, found_index, free_block_count, free_byte_count,
                output ready);
endinterface

[hw/rtl/block_bitmap_allocator_top.sv]
// Block bitmap allocator top level: configuration registers, bitmaps and sequencer.
//
// Keeps a free map and a master map over NUM_BLOCKS blocks as 16-bit words, plus
// free block and free byte counters; every request gives one result. Clear, init
// finish, format and out-of-pool requests end in the execute state; single-block
// updates issue the registered word read as the request is accepted, then write the
// word in the modify state. Allocate and seek scan one map word per cycle through
// the shared lowest-bit finder: allocate scans from word 0, seek from the start
// block's word, at most ceil(NUM_BLOCKS/16) words. Requests are taken one at a
// time; a finished result waits in the output register, and the next request is
// taken but holds in its last cycle until that register frees. Clears and format
// are immediate (per-word valid bits), so no clearing pass runs after reset.
module block_bitmap_allocator_top import bba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bba_in_if.sink           in_ch,
  bba_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [CFG_W-1:0]     data_bytes_r;
  logic [CFG_W-1:0]     name_bytes_r;
  map_ctl_t             free_ctl, mast_ctl;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] free_wdata, mast_wdata, free_dflt, free_q, mast_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bytes_r <= DATA_BYTES_RST;
      name_bytes_r <= NAME_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_BYTES: data_bytes_r <= cfg_wdata;
        CFG_NAME_BYTES: name_bytes_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bba_map #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_free_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (free_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (free_wdata),
    .dflt_word (free_dflt),
    .rd_data   (free_q)
  );

  bba_map #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_mast_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mast_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (mast_wdata),
    .dflt_word ('0),
    .rd_data   (mast_q)
  );

  bba_seq #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .NUM_WORDS  (NUM_WORDS),
    .AW         (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .data_bytes (data_bytes_r),
    .name_bytes (name_bytes_r),
    .free_ctl   (free_ctl),
    .mast_ctl   (mast_ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .free_wdata (free_wdata),
    .mast_wdata (mast_wdata),
    .free_dflt  (free_dflt),
    .free_q     (free_q),
    .mast_q     (mast_q)
  );

endmodule

[hw/rtl/bba_map.sv]
// One bitmap stored as words, with a valid bit per word so a clear takes effect on every word at once.
module bba_map import bba_pkg::*; #(
  parameter int NUM_WORDS = 16,
  parameter int AW        = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  map_ctl_t             ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic [WORD_BITS-1:0] dflt_word,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      q_r <= vld_r[rd_addr] ? mem[rd_addr] : dflt_word;
    end
  end

  assign rd_data = q_r;

endmodule

[hw/rtl/bba_pick.sv]
// Lowest-set-bit finder over one bitmap word.
module bba_pick import bba_pkg::*; (
  input  logic [WORD_BITS-1:0] word,
  output logic                 hit,
  output logic [WBIT_W-1:0]    pos
);

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        pos = WBIT_W'(i);
      end
    end
  end

  assign hit = |word;

endmodule

[hw/rtl/bba_seq.sv]
// Sequencer: walks the bitmap words, updates maps and counters, holds the result register.
module bba_seq import bba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int NUM_WORDS  = 16,
  parameter int AW         = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bba_in_if.sink               in_ch,
  bba_out_if.source            out_ch,
  input  logic [CFG_W-1:0]     data_bytes,
  input  logic [CFG_W-1:0]     name_bytes,
  output map_ctl_t             free_ctl,
  output map_ctl_t             mast_ctl,
  output logic [AW-1:0]        rd_addr,
  output logic [AW-1:0]        wr_addr,
  output logic [WORD_BITS-1:0] free_wdata,
  output logic [WORD_BITS-1:0] mast_wdata,
  output logic [WORD_BITS-1:0] free_dflt,
  input  logic [WORD_BITS-1:0] free_q,
  input  logic [WORD_BITS-1:0] mast_q
);

  localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int IW    = (BLK_W > IDX_W) ? BLK_W : IDX_W;
  localparam int PW    = $clog2(NUM_BLOCKS + 1) + CFG_W;
  localparam logic [BLKS_W-1:0] FMT_BLOCKS =
    BLKS_W'((NUM_BLOCKS > int'(BLOCKS_MAX)) ? int'(BLOCKS_MAX) : NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r;
  logic [IW-1:0]      idx_r;
  logic               in_pool_r;
  logic               skip_r;
  logic [HDR_W-1:0]   hdr_r;
  logic               fmt_r;
  logic               first_r, first_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               fill_r, fill_nxt;
  logic [BLKS_W-1:0]  blocks_r, blocks_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;

  logic               ov_r, ov_nxt;
  logic               ostat_r, ostat_nxt;
  logic [IDX_W-1:0]   ofound_r, ofound_nxt;

  logic                 accept, go, needs_mem, in_pool_in, fb;
  logic [IW-1:0]        idx_in;
  logic [WORD_BITS-1:0] bsel, scan_word;
  logic                 hit, is_scan, skip_here;
  logic [WBIT_W-1:0]    pos;
  logic [AW+WBIT_W-1:0] fidx;
  logic [PW-1:0]        fmt_prod;
  logic [BYTES_W-1:0]   fmt_bytes;
  logic [BLKS_W:0]      blk_inc;
  logic [BYTES_W:0]     byt_inc;
  logic [BLKS_W-1:0]    blk_up, blk_dn;
  logic [BYTES_W-1:0]   byt_up, byt_dn, byt_name;

  bba_pick u_pick (
    .word (scan_word),
    .hit  (hit),
    .pos  (pos)
  );

  assign idx_in     = IW'(in_ch.block_index);
  assign in_pool_in = (int'(idx_in) < NUM_BLOCKS);
  assign accept     = (state_r == S_IDLE) && in_ch.valid;
  assign go         = !ov_r || out_ch.ready;

  always_comb begin
    case (in_ch.kind)
      KIND_ALLOC:                       needs_mem = 1'b1;
      KIND_INIT_HEADER, KIND_RELEASE,
      KIND_MASTER_SET, KIND_MASTER_CLR: needs_mem = in_pool_in;
      KIND_SEEK_FMT:                    needs_mem = !in_ch.format_select && in_pool_in;
      default:                          needs_mem = 1'b0;
    endcase
  end

  assign bsel      = WORD_BITS'(1) << idx_r[WBIT_W-1:0];
  assign fb        = free_q[idx_r[WBIT_W-1:0]];
  assign is_scan   = (kind_r == KIND_ALLOC) || (kind_r == KIND_SEEK_FMT);
  assign skip_here = skip_r && in_pool_r && (addr_r == idx_r[WBIT_W +: AW]);
  assign fidx      = {addr_r, pos};

  always_comb begin
    if (kind_r == KIND_ALLOC) begin
      scan_word = free_q & ~(skip_here ? bsel : '0);
    end else begin
      scan_word = mast_q & (first_r ? ~(bsel - WORD_BITS'(1)) : '1);
    end
  end

  // saturating counter steps
  assign blk_inc  = {1'b0, blocks_r} + (BLKS_W+1)'(1);
  assign blk_up   = blk_inc[BLKS_W] ? BLOCKS_MAX : blk_inc[BLKS_W-1:0];
  assign blk_dn   = (blocks_r != '0) ? blocks_r - BLKS_W'(1) : '0;
  assign byt_inc  = {1'b0, bytes_r} + (BYTES_W+1)'(data_bytes);
  assign byt_up   = byt_inc[BYTES_W] ? BYTES_MAX : byt_inc[BYTES_W-1:0];
  assign byt_dn   = (bytes_r > BYTES_W'(data_bytes)) ? bytes_r - BYTES_W'(data_bytes) : '0;
  assign byt_name = (bytes_r > BYTES_W'(name_bytes)) ? bytes_r - BYTES_W'(name_bytes) : '0;
  assign fmt_prod  = PW'(NUM_BLOCKS) * PW'(data_bytes);
  assign fmt_bytes = (fmt_prod > PW'(BYTES_MAX)) ? BYTES_MAX : BYTES_W'(fmt_prod);

  // free-map word value for rows not written since the last clear
  always_comb begin
    free_dflt = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      free_dflt[j] = fill_r && ((int'(rd_addr) * WORD_BITS + j) < NUM_BLOCKS);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    first_nxt  = first_r;
    addr_nxt   = addr_r;
    fill_nxt   = fill_r;
    blocks_nxt = blocks_r;
    bytes_nxt  = bytes_r;
    ov_nxt     = ov_r && !out_ch.ready;
    ostat_nxt  = ostat_r;
    ofound_nxt = ofound_r;
    free_ctl   = '0;
    mast_ctl   = '0;
    rd_addr    = addr_r;
    wr_addr    = addr_r;
    free_wdata = free_q;
    mast_wdata = mast_q;

    case (state_r)
      S_IDLE: begin
        rd_addr = (in_ch.kind == KIND_ALLOC) ? '0 : idx_in[WBIT_W +: AW];
        if (accept) begin
          addr_nxt       = rd_addr;
          first_nxt      = 1'b1;
          free_ctl.rd_en = needs_mem;
          mast_ctl.rd_en = needs_mem;
          state_nxt      = needs_mem ? S_MOD : S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          case (kind_r)
            KIND_INIT_CLEAR: begin
              free_ctl.clr = 1'b1;
              mast_ctl.clr = 1'b1;
              fill_nxt     = 1'b0;
              blocks_nxt   = '0;
              bytes_nxt    = '0;
            end
            KIND_INIT_FINISH: begin
              if (bytes_r != '0) begin
                bytes_nxt = byt_name;
              end
            end
            KIND_SEEK_FMT: begin
              if (fmt_r) begin
                free_ctl.clr = 1'b1;
                mast_ctl.clr = 1'b1;
                fill_nxt     = 1'b1;
                blocks_nxt   = FMT_BLOCKS;
                bytes_nxt    = fmt_bytes;
              end
            end
            default: begin
            end
          endcase
          ostat_nxt  = (kind_r == KIND_SEEK_FMT && !fmt_r) ? STATUS_NONE : STATUS_OK;
          ofound_nxt = '0;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_MOD: begin
        if (is_scan && !hit && (addr_r != LAST_WORD)) begin
          rd_addr        = addr_r + AW'(1);
          addr_nxt       = rd_addr;
          first_nxt      = 1'b0;
          free_ctl.rd_en = 1'b1;
          mast_ctl.rd_en = 1'b1;
        end else if (go) begin
          ostat_nxt  = STATUS_OK;
          ofound_nxt = '0;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
          if (is_scan) begin
            ostat_nxt  = hit ? STATUS_OK : STATUS_NONE;
            ofound_nxt = hit ? IDX_W'(fidx) : '0;
            if (hit && kind_r == KIND_ALLOC) begin
              free_wdata     = free_q & ~(WORD_BITS'(1) << pos);
              free_ctl.wr_en = 1'b1;
              blocks_nxt     = blk_dn;
              bytes_nxt      = byt_dn;
            end
          end else begin
            free_ctl.wr_en = 1'b1;
            mast_ctl.wr_en = 1'b1;
            case (kind_r)
              KIND_INIT_HEADER: begin
                if (hdr_r == '0) begin
                  free_wdata = free_q | bsel;
                  if (!fb) begin
                    blocks_nxt = blk_up;
                    bytes_nxt  = byt_up;
                  end
                end
                if (hdr_r[0]) begin
                  mast_wdata = mast_q | bsel;
                end
              end
              KIND_RELEASE: begin
                free_wdata = free_q | bsel;
                if (!fb) begin
                  blocks_nxt = blk_up;
                  bytes_nxt  = byt_up;
                end
              end
              KIND_MASTER_SET: mast_wdata = mast_q | bsel;
              KIND_MASTER_CLR: mast_wdata = mast_q & ~bsel;
              default: begin
              end
            endcase
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= 1'b0;
      blocks_r <= '0;
      bytes_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      blocks_r <= blocks_nxt;
      bytes_r  <= bytes_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_ch.kind;
      idx_r     <= idx_in;
      in_pool_r <= in_pool_in;
      skip_r    <= in_ch.skip_valid;
      hdr_r     <= in_ch.header_byte;
      fmt_r     <= in_ch.format_select;
    end
    first_r  <= first_nxt;
    addr_r   <= addr_nxt;
    ostat_r  <= ostat_nxt;
    ofound_r <= ofound_nxt;
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = ov_r;
  assign out_ch.status           = ostat_r;
  assign out_ch.found_index      = ofound_r;
  assign out_ch.free_block_count = blocks_r;
  assign out_ch.free_byte_count  = bytes_r;

endmodule

[dv/block_bitmap_allocator_top_tb.sv]
// Self-checking testbench for block_bitmap_allocator_top: directed table, then random traffic.
`timescale 1ns / 1ps

module block_bitmap_allocator_top_tb import bba_pkg::*; ();

  localparam int POOL         = NUM_BLOCKS_DEF;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic              skip;
    logic [HDR_W-1:0]  hdr;
    logic              fmt;
  } pool_req_t;

  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   found;
    logic [BLKS_W-1:0]  blocks;
    logic [BYTES_W-1:0] bytes;
  } pool_rsp_t;

  typedef struct {
    pool_req_t req;
    bit        typed;
    pool_rsp_t rsp;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  block_bitmap_allocator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model state
  bit [POOL-1:0] free_map;
  bit [POOL-1:0] master_map;
  int            free_blk_cnt;
  int            free_byte_cnt;
  int            cfg_blk_bytes;
  int            cfg_name_bytes;

  pool_rsp_t   pool_rsp_q[$];
  pool_req_t   req_plan_q[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          hold_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("block_bitmap_allocator_top test failed");
      $finish;
    end
  end

  function automatic void count_free();
    free_blk_cnt  = (free_blk_cnt + 1 > int'(BLOCKS_MAX)) ? int'(BLOCKS_MAX) : free_blk_cnt + 1;
    free_byte_cnt = (free_byte_cnt + cfg_blk_bytes > int'(BYTES_MAX)) ?
                    int'(BYTES_MAX) : free_byte_cnt + cfg_blk_bytes;
  endfunction

  function automatic pool_rsp_t pool_step(pool_req_t r);
    pool_rsp_t rsp;
    bit        in_pool;
    bit        hit;
    int        i;
    rsp     = '0;
    hit     = 1'b0;
    in_pool = int'(r.idx) < POOL;
    rsp.status = STATUS_OK;
    case (r.kind)
      KIND_INIT_CLEAR: begin
        free_map      = '0;
        master_map    = '0;
        free_blk_cnt  = 0;
        free_byte_cnt = 0;
      end
      KIND_INIT_HEADER: begin
        if (in_pool) begin
          if (r.hdr == '0 && !free_map[r.idx]) begin
            free_map[r.idx] = 1'b1;
            count_free();
          end
          if (r.hdr[0]) master_map[r.idx] = 1'b1;
        end
      end
      KIND_INIT_FINISH: begin
        if (free_byte_cnt > 0)
          free_byte_cnt = (free_byte_cnt > cfg_name_bytes) ? free_byte_cnt - cfg_name_bytes : 0;
      end
      KIND_ALLOC: begin
        for (i = 0; i < POOL; i++) begin
          if (!(r.skip && i == int'(r.idx)) && free_map[i]) begin
            free_map[i]   = 1'b0;
            free_blk_cnt  = (free_blk_cnt > 1) ? free_blk_cnt - 1 : 0;
            free_byte_cnt = (free_byte_cnt > cfg_blk_bytes) ? free_byte_cnt - cfg_blk_bytes : 0;
            rsp.found     = i[IDX_W-1:0];
            hit           = 1'b1;
            break;
          end
        end
        if (!hit) rsp.status = STATUS_NONE;
      end
      KIND_RELEASE: begin
        if (in_pool && !free_map[r.idx]) begin
          free_map[r.idx] = 1'b1;
          count_free();
        end
      end
      KIND_MASTER_SET: begin
        if (in_pool) master_map[r.idx] = 1'b1;
      end
      KIND_MASTER_CLR: begin
        if (in_pool) master_map[r.idx] = 1'b0;
      end
      KIND_SEEK_FMT: begin
        if (r.fmt) begin
          free_map      = '1;
          master_map    = '0;
          free_blk_cnt  = (POOL > int'(BLOCKS_MAX)) ? int'(BLOCKS_MAX) : POOL;
          free_byte_cnt = POOL * cfg_blk_bytes;
          if (free_byte_cnt > int'(BYTES_MAX)) free_byte_cnt = int'(BYTES_MAX);
        end else begin
          for (i = int'(r.idx); i < POOL; i++) begin
            if (master_map[i]) begin
              rsp.found = i[IDX_W-1:0];
              hit       = 1'b1;
              break;
            end
          end
          if (!hit) rsp.status = STATUS_NONE;
        end
      end
      default: ;
    endcase
    rsp.blocks = free_blk_cnt[BLKS_W-1:0];
    rsp.bytes  = free_byte_cnt[BYTES_W-1:0];
    return rsp;
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] k, input int idx, input bit skip,
                         input int hdr, input bit fmt, input bit typed, input bit st,
                         input int found, input int blocks, input int bytes);
    dir_row_t row;
    row.req   = '{k, idx[IDX_W-1:0], skip, hdr[HDR_W-1:0], fmt};
    row.typed = typed;
    row.rsp   = '{st, found[IDX_W-1:0], blocks[BLKS_W-1:0], bytes[BYTES_W-1:0]};
    dir_rows.push_back(row);
  endtask

  function automatic logic [IDX_W-1:0] rand_index();
    return $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 255)) : IDX_W'($urandom_range(0, 31));
  endfunction

  // Either an init pass (clear, headers over a run of blocks, finish) or one random op.
  task automatic plan_random();
    pool_req_t r;
    int        r_sel;
    int        n;
    int        base;
    int        j;
    r_sel = $urandom_range(0, 99);
    if (r_sel < 3) begin
      n    = $urandom_range(4, 40);
      base = $urandom_range(0, 255 - n);
      r    = '{KIND_INIT_CLEAR, rand_index(), 1'($urandom), 8'($urandom), 1'($urandom)};
      req_plan_q.push_back(r);
      for (j = 0; j < n; j++) begin
        r.kind = KIND_INIT_HEADER;
        r.idx  = IDX_W'(base + j);
        r.hdr  = ($urandom_range(0, 9) < 6) ? 8'h00 : 8'($urandom);
        r.skip = 1'($urandom);
        r.fmt  = 1'($urandom);
        req_plan_q.push_back(r);
      end
      r.kind = KIND_INIT_FINISH;
      req_plan_q.push_back(r);
    end else begin
      r.idx  = rand_index();
      r.skip = 1'($urandom);
      r.fmt  = 1'($urandom);
      case ($urandom_range(0, 3))
        0:       r.hdr = 8'h00;
        1:       r.hdr = 8'($urandom) | 8'h01;
        default: r.hdr = 8'($urandom);
      endcase
      r_sel = $urandom_range(0, 99);
      if (r_sel < 30)      r.kind = KIND_ALLOC;
      else if (r_sel < 53) r.kind = KIND_RELEASE;
      else if (r_sel < 61) r.kind = KIND_MASTER_SET;
      else if (r_sel < 67) r.kind = KIND_MASTER_CLR;
      else if (r_sel < 78) begin
        r.kind = KIND_SEEK_FMT;
        r.fmt  = 1'b0;
      end
      else if (r_sel < 91) r.kind = KIND_INIT_HEADER;
      else if (r_sel < 93) r.kind = KIND_INIT_CLEAR;
      else if (r_sel < 96) r.kind = KIND_INIT_FINISH;
      else begin
        r.kind = KIND_SEEK_FMT;
        r.fmt  = 1'b1;
      end
      req_plan_q.push_back(r);
    end
  endtask

  // Called on a falling edge; returns on the falling edge after the transfer.
  task automatic send_item(input pool_req_t r, input bit typed, input pool_rsp_t typed_rsp);
    pool_rsp_t rsp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= r.kind;
    in_ch.block_index   <= r.idx;
    in_ch.skip_valid    <= r.skip;
    in_ch.header_byte   <= r.hdr;
    in_ch.format_select <= r.fmt;
    do @(posedge clk); while (!in_ch.ready);
    rsp = pool_step(r);
    pool_rsp_q.push_back(typed ? typed_rsp : rsp);
    @(negedge clk);
  endtask

  task automatic drain_pool();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pool_rsp_q.size() != 0);
  endtask

  task automatic write_cfg(input int blk_bytes, input int name_bytes);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DATA_BYTES;
    cfg_wdata <= CFG_W'(blk_bytes);
    @(negedge clk);
    cfg_index <= CFG_NAME_BYTES;
    cfg_wdata <= CFG_W'(name_bytes);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_blk_bytes  = blk_bytes;
    cfg_name_bytes = name_bytes;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  pool_rsp_t oldest_rsp;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pool_rsp_q.size() == 0) begin
        $display("%0t: result with none outstanding: status %0d found %0d blocks %0d bytes %0d",
                 $time, out_ch.status, out_ch.found_index, out_ch.free_block_count,
                 out_ch.free_byte_count);
        mismatch_cnt++;
      end else begin
        oldest_rsp = pool_rsp_q.pop_front();
        check_field("status", oldest_rsp.status, out_ch.status);
        check_field("found_index", oldest_rsp.found, out_ch.found_index);
        check_field("free_block_count", oldest_rsp.blocks, out_ch.free_block_count);
        check_field("free_byte_count", oldest_rsp.bytes, out_ch.free_byte_count);
      end
    end
  end

  initial begin
    int ph;
    int n;
    int blk_bytes;
    int name_bytes;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_DATA_BYTES;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_INIT_CLEAR;
    in_ch.block_index   = '0;
    in_ch.skip_valid    = 1'b0;
    in_ch.header_byte   = '0;
    in_ch.format_select = 1'b0;
    out_ch.ready        = 1'b0;
    hold_req            = 1'b0;
    hold_left           = 0;
    mismatch_cnt        = 0;
    cycle_cnt           = 0;
    send_idle_pct       = 25;
    recv_idle_pct       = 79;

    free_map       = '0;
    master_map     = '0;
    free_blk_cnt   = 0;
    free_byte_cnt  = 0;
    cfg_blk_bytes  = int'(DATA_BYTES_RST);
    cfg_name_bytes = int'(NAME_BYTES_RST);

    // empty pool, format, claim/release, master walk, init pass, skip of the only free block
    add_row(KIND_INIT_FINISH, 0, 0, 0, 0, 1, STATUS_OK, 0, 0, 0);
    add_row(KIND_ALLOC, 0, 0, 0, 0, 1, STATUS_NONE, 0, 0, 0);
    add_row(KIND_SEEK_FMT, 0, 0, 0, 0, 1, STATUS_NONE, 0, 0, 0);
    add_row(KIND_SEEK_FMT, 0, 0, 0, 1, 1, STATUS_OK, 0, 256, 7424);
    add_row(KIND_ALLOC, 0, 0, 0, 0, 1, STATUS_OK, 0, 255, 7395);
    add_row(KIND_ALLOC, 1, 1, 0, 0, 1, STATUS_OK, 2, 254, 7366);
    add_row(KIND_RELEASE, 0, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
    add_row(KIND_RELEASE, 255, 0, 0, 0, 1, STATUS_OK, 0, 255, 7395);
    add_row(KIND_MASTER_SET, 255, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
    add_row(KIND_SEEK_FMT, 0, 0, 0, 0, 1, STATUS_OK, 255, 255, 7395);
    add_row(KIND_MASTER_SET, 0, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
    add_row(KIND_SEEK_FMT, 0, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
    add_row(KIND_MASTER_CLR, 0, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
    add_row(KIND_SEEK_FMT, 255, 0, 0, 0, 1, STATUS_OK, 255, 255, 7395);
    add_row(KIND_MASTER_CLR, 255, 0, 0, 0, 0, STATUS_OK, 0, 0, 0);
    add_row(KIND_SEEK_FMT, 0, 0, 0, 0, 1, STATUS_NONE, 0, 255, 7395);
    add_row(KIND_INIT_CLEAR, 255, 1, 255, 1, 1, STATUS_OK, 0, 0, 0);
    add_row(KIND_INIT_HEADER, 5, 0, 0, 0, 1, STATUS_OK, 0, 1, 29);
    add_row(KIND_INIT_HEADER, 5, 0, 0, 0, 1, STATUS_OK, 0, 1, 29);
    add_row(KIND_INIT_HEADER, 255, 0, 255, 0, 0, STATUS_OK, 0, 0, 0);
    add_row(KIND_INIT_HEADER, 7, 0, 128, 0, 0, STATUS_OK, 0, 0, 0);
    add_row(KIND_SEEK_FMT, 8, 0, 0, 0, 1, STATUS_OK, 255, 1, 29);
    add_row(KIND_INIT_FINISH, 0, 0, 0, 0, 1, STATUS_OK, 0, 1, 13);
    add_row(KIND_ALLOC, 5, 1, 0, 0, 1, STATUS_NONE, 0, 1, 13);
    add_row(KIND_ALLOC, 0, 0, 0, 0, 1, STATUS_OK, 5, 0, 0);
    add_row(KIND_INIT_FINISH, 0, 0, 0, 0, 1, STATUS_OK, 0, 0, 0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    for (ph = 0; ph < PHASES; ph++) begin
      drain_pool();
      case (ph)
        0: begin blk_bytes = 1;   name_bytes = 0;   end
        1: begin blk_bytes = 127; name_bytes = 127; end
        2: begin blk_bytes = 1;   name_bytes = 127; end
        3: begin blk_bytes = 127; name_bytes = 0;   end
        4: begin
          blk_bytes  = $urandom_range(1, 127);
          name_bytes = $urandom_range(0, 127);
        end
        default: begin
          blk_bytes  = int'(DATA_BYTES_RST);
          name_bytes = int'(NAME_BYTES_RST);
        end
      endcase
      write_cfg(blk_bytes, name_bytes);
      send_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 79 : 0;
      recv_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 25 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (req_plan_q.size() == 0) plan_random();
        send_item(req_plan_q.pop_front(), 1'b0, '0);
        if (ph == 4 && n == 40) hold_req = 1'b1;
        if (ph == 5 && n == 100) drain_pool();
      end
    end

    drain_pool();
    repeat (40) @(negedge clk);
    if (mismatch_cnt == 0 && pool_rsp_q.size() == 0) begin
      $display("block_bitmap_allocator_top test passed");
    end else begin
      $display("block_bitmap_allocator_top test failed");
    end
    $finish;
  end

endmodule
